@@ rtl/vba_pkg.sv @@
package vba_pkg;

   localparam int unsigned NUM_BANKS  = 9;
   localparam int unsigned NUM_USES   = 8;
   localparam int unsigned TBL_DEPTH  = 4;

   typedef logic [NUM_BANKS-1:0] bank_mask_type;

   typedef enum logic [3:0] {
      OP_SET_BG           = 4'd0,
      OP_SET_OBJ          = 4'd1,
      OP_SET_BGEXT        = 4'd2,
      OP_SET_OBJEXT       = 4'd3,
      OP_SET_SUBBG        = 4'd4,
      OP_SET_SUBOBJ       = 4'd5,
      OP_SET_SUBBGEXT     = 4'd6,
      OP_SET_SUBOBJEXT    = 4'd7,
      OP_POOL_ADD         = 4'd8,
      OP_RESET_BGEXT      = 4'd9,
      OP_RESET_OBJEXT     = 4'd10,
      OP_RESET_SUBBGEXT   = 4'd11,
      OP_RESET_SUBOBJEXT  = 4'd12,
      OP_DISABLE_POOL     = 4'd13
   } op_type;

   localparam logic [3:0] TGT_BANK_A      = 4'd0;
   localparam logic [3:0] TGT_BANK_B      = 4'd1;
   localparam logic [3:0] TGT_BANK_C      = 4'd2;
   localparam logic [3:0] TGT_BANK_D      = 4'd3;
   localparam logic [3:0] TGT_BANK_E      = 4'd4;
   localparam logic [3:0] TGT_BANK_F      = 4'd5;
   localparam logic [3:0] TGT_BANK_G      = 4'd6;
   localparam logic [3:0] TGT_BANK_H      = 4'd7;
   localparam logic [3:0] TGT_BANK_I      = 4'd8;
   localparam logic [3:0] TGT_DISP_BGEXT  = 4'd9;
   localparam logic [3:0] TGT_DISP_OBJEXT = 4'd10;
   localparam logic [3:0] TGT_DISP_SBGEXT = 4'd11;
   localparam logic [3:0] TGT_DISP_SOBJEXT = 4'd12;
   localparam logic [3:0] TGT_DONE        = 4'd13;

   localparam logic [7:0] VAL_POOL    = 8'h80;
   localparam logic [7:0] VAL_DISABLE = 8'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TABLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]    op;
      bank_mask_type bank_mask;
   } req_type;

   typedef struct packed {
      logic [3:0]    write_target;
      logic [7:0]    write_value;
      bank_mask_type returned_mask;
      logic          last;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] target;
      logic [7:0] value;
   } tbl_entry_type;

   function automatic tbl_entry_type mk(input logic [3:0] target, input logic [7:0] value);
      tbl_entry_type e;
      e.valid  = 1'b1;
      e.target = target;
      e.value  = value;
      return e;
   endfunction

   // control writes of one set or reset op, in order, empty slots invalid
   function automatic tbl_entry_type tbl_lookup(input logic [3:0] op, input bank_mask_type m,
                                                input logic [1:0] idx);
      tbl_entry_type l [TBL_DEPTH];
      for (int i = 0; i < TBL_DEPTH; i++) begin
         l[i] = '0;
      end
      case (op)
         OP_SET_BG: begin
            case (m)
               9'h008: l[0] = mk(TGT_BANK_D, 8'h81);
               9'h00c: begin
                  l[0] = mk(TGT_BANK_D, 8'h89); l[1] = mk(TGT_BANK_C, 8'h81);
               end
               9'h004: l[0] = mk(TGT_BANK_C, 8'h81);
               9'h00e: begin
                  l[0] = mk(TGT_BANK_D, 8'h91); l[1] = mk(TGT_BANK_C, 8'h89);
                  l[2] = mk(TGT_BANK_B, 8'h81);
               end
               9'h006: begin
                  l[0] = mk(TGT_BANK_C, 8'h89); l[1] = mk(TGT_BANK_B, 8'h81);
               end
               9'h002: l[0] = mk(TGT_BANK_B, 8'h81);
               9'h00f: begin
                  l[0] = mk(TGT_BANK_D, 8'h99); l[1] = mk(TGT_BANK_C, 8'h91);
                  l[2] = mk(TGT_BANK_B, 8'h89); l[3] = mk(TGT_BANK_A, 8'h81);
               end
               9'h007: begin
                  l[0] = mk(TGT_BANK_C, 8'h91); l[1] = mk(TGT_BANK_B, 8'h89);
                  l[2] = mk(TGT_BANK_A, 8'h81);
               end
               9'h003: begin
                  l[0] = mk(TGT_BANK_B, 8'h89); l[1] = mk(TGT_BANK_A, 8'h81);
               end
               9'h001: l[0] = mk(TGT_BANK_A, 8'h81);
               9'h00b: begin
                  l[0] = mk(TGT_BANK_A, 8'h81); l[1] = mk(TGT_BANK_B, 8'h89);
                  l[2] = mk(TGT_BANK_D, 8'h91);
               end
               9'h00d: begin
                  l[0] = mk(TGT_BANK_D, 8'h91); l[1] = mk(TGT_BANK_A, 8'h81);
                  l[2] = mk(TGT_BANK_C, 8'h89);
               end
               9'h005: begin
                  l[0] = mk(TGT_BANK_A, 8'h81); l[1] = mk(TGT_BANK_C, 8'h89);
               end
               9'h009: begin
                  l[0] = mk(TGT_BANK_A, 8'h81); l[1] = mk(TGT_BANK_D, 8'h89);
               end
               9'h00a: begin
                  l[0] = mk(TGT_BANK_B, 8'h81); l[1] = mk(TGT_BANK_D, 8'h89);
               end
               9'h070: begin
                  l[0] = mk(TGT_BANK_G, 8'h99); l[1] = mk(TGT_BANK_F, 8'h91);
                  l[2] = mk(TGT_BANK_E, 8'h81);
               end
               9'h030: begin
                  l[0] = mk(TGT_BANK_F, 8'h91); l[1] = mk(TGT_BANK_E, 8'h81);
               end
               9'h010: l[0] = mk(TGT_BANK_E, 8'h81);
               9'h050: begin
                  l[0] = mk(TGT_BANK_G, 8'h91); l[1] = mk(TGT_BANK_E, 8'h81);
               end
               9'h060: begin
                  l[0] = mk(TGT_BANK_G, 8'h89); l[1] = mk(TGT_BANK_F, 8'h81);
               end
               9'h020: l[0] = mk(TGT_BANK_F, 8'h81);
               9'h040: l[0] = mk(TGT_BANK_G, 8'h81);
               default: ;
            endcase
         end
         OP_SET_OBJ: begin
            case (m)
               9'h003: begin
                  l[0] = mk(TGT_BANK_B, 8'h8a); l[1] = mk(TGT_BANK_A, 8'h82);
               end
               9'h001: l[0] = mk(TGT_BANK_A, 8'h82);
               9'h002: l[0] = mk(TGT_BANK_B, 8'h82);
               9'h070: begin
                  l[0] = mk(TGT_BANK_G, 8'h9a); l[1] = mk(TGT_BANK_F, 8'h92);
                  l[2] = mk(TGT_BANK_E, 8'h82);
               end
               9'h030: begin
                  l[0] = mk(TGT_BANK_F, 8'h92); l[1] = mk(TGT_BANK_E, 8'h82);
               end
               9'h010: l[0] = mk(TGT_BANK_E, 8'h82);
               9'h050: begin
                  l[0] = mk(TGT_BANK_G, 8'h92); l[1] = mk(TGT_BANK_E, 8'h82);
               end
               9'h060: begin
                  l[0] = mk(TGT_BANK_G, 8'h8a); l[1] = mk(TGT_BANK_F, 8'h82);
               end
               9'h020: l[0] = mk(TGT_BANK_F, 8'h82);
               9'h040: l[0] = mk(TGT_BANK_G, 8'h82);
               default: ;
            endcase
         end
         OP_SET_BGEXT: begin
            case (m)
               9'h010: begin
                  l[0] = mk(TGT_DISP_BGEXT, 8'h01); l[1] = mk(TGT_BANK_E, 8'h84);
               end
               9'h040: begin
                  l[0] = mk(TGT_DISP_BGEXT, 8'h01); l[1] = mk(TGT_BANK_G, 8'h8c);
               end
               9'h060: begin
                  l[0] = mk(TGT_BANK_G, 8'h8c); l[1] = mk(TGT_BANK_F, 8'h84);
                  l[2] = mk(TGT_DISP_BGEXT, 8'h01);
               end
               9'h020: begin
                  l[0] = mk(TGT_BANK_F, 8'h84); l[1] = mk(TGT_DISP_BGEXT, 8'h01);
               end
               9'h000: l[0] = mk(TGT_DISP_BGEXT, 8'h00);
               default: ;
            endcase
         end
         OP_SET_OBJEXT: begin
            case (m)
               9'h020: begin
                  l[0] = mk(TGT_DISP_OBJEXT, 8'h01); l[1] = mk(TGT_BANK_F, 8'h85);
               end
               9'h040: begin
                  l[0] = mk(TGT_DISP_OBJEXT, 8'h01); l[1] = mk(TGT_BANK_G, 8'h85);
               end
               9'h000: l[0] = mk(TGT_DISP_OBJEXT, 8'h00);
               default: ;
            endcase
         end
         OP_SET_SUBBG: begin
            case (m)
               9'h004: l[0] = mk(TGT_BANK_C, 8'h84);
               9'h180: begin
                  l[0] = mk(TGT_BANK_I, 8'h81); l[1] = mk(TGT_BANK_H, 8'h81);
               end
               9'h080: l[0] = mk(TGT_BANK_H, 8'h81);
               default: ;
            endcase
         end
         OP_SET_SUBOBJ: begin
            case (m)
               9'h008: l[0] = mk(TGT_BANK_D, 8'h84);
               9'h100: l[0] = mk(TGT_BANK_I, 8'h82);
               default: ;
            endcase
         end
         OP_SET_SUBBGEXT: begin
            case (m)
               9'h080: begin
                  l[0] = mk(TGT_DISP_SBGEXT, 8'h01); l[1] = mk(TGT_BANK_H, 8'h82);
               end
               9'h000: l[0] = mk(TGT_DISP_SBGEXT, 8'h00);
               default: ;
            endcase
         end
         OP_SET_SUBOBJEXT: begin
            case (m)
               9'h100: begin
                  l[0] = mk(TGT_DISP_SOBJEXT, 8'h01); l[1] = mk(TGT_BANK_I, 8'h83);
               end
               9'h000: l[0] = mk(TGT_DISP_SOBJEXT, 8'h00);
               default: ;
            endcase
         end
         OP_RESET_BGEXT:     l[0] = mk(TGT_DISP_BGEXT, 8'h00);
         OP_RESET_OBJEXT:    l[0] = mk(TGT_DISP_OBJEXT, 8'h00);
         OP_RESET_SUBBGEXT:  l[0] = mk(TGT_DISP_SBGEXT, 8'h00);
         OP_RESET_SUBOBJEXT: l[0] = mk(TGT_DISP_SOBJEXT, 8'h00);
         default: ;
      endcase
      return l[idx];
   endfunction

endpackage

@@ rtl/video_bank_assignment.sv @@
// Each item issues its table writes, then its bank sweep writes, then a done item last.
// A new item is not taken until the done item of the last one has been issued.
// The bank sweep visits all nine banks one per cycle unless the result side stalls, after up to four table writes.
// Reset: pool and all use masks cleared, sequencer idle, no result pending.
module video_bank_assignment (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vba_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vba_pkg::rsp_type rsp_item
);
   import vba_pkg::*;

   state_type     state_ff, state_in;
   logic [3:0]    op_ff;
   bank_mask_type mask_ff;
   bank_mask_type pool_ff;
   bank_mask_type use_ff [NUM_USES];
   bank_mask_type sweep_mask_ff;
   logic [7:0]    sweep_value_ff;
   bank_mask_type ret_ff;
   logic [1:0]    idx_ff;
   logic [3:0]    bank_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          req_accept;
   logic          out_free;
   tbl_entry_type entry;
   logic          emit_tbl, emit_bank, emit_done;
   logic          idx_inc, bank_inc;
   logic [2:0]    ext_use;
   logic [2:0]    set_use;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign entry      = tbl_lookup(op_ff, mask_ff, idx_ff);
   assign ext_use    = {req_item.op[1] ^ req_item.op[0] ^ 1'b1, 1'b1, ~req_item.op[0]};
   assign set_use    = req_item.op[2:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_TABLE;
         end
         ST_TABLE: begin
            if (!entry.valid) state_in = ST_SWEEP;
            else if (out_free && idx_ff == 2'(TBL_DEPTH - 1)) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if ((!sweep_mask_ff[bank_ff] || out_free) && bank_ff == 4'(NUM_BANKS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer strobes
   always_comb begin
      emit_tbl  = 1'b0;
      emit_bank = 1'b0;
      emit_done = 1'b0;
      idx_inc   = 1'b0;
      bank_inc  = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_TABLE: begin
            emit_tbl = entry.valid && out_free;
            idx_inc  = emit_tbl;
         end
         ST_SWEEP: begin
            emit_bank = sweep_mask_ff[bank_ff] && out_free;
            bank_inc  = !sweep_mask_ff[bank_ff] || out_free;
         end
         ST_DONE: emit_done = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= '0;
         for (int i = 0; i < NUM_USES; i++) begin
            use_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (emit_tbl || emit_bank || emit_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_accept) begin
            priority if (req_item.op < OP_POOL_ADD) begin
               pool_ff         <= ~req_item.bank_mask & (pool_ff | use_ff[set_use]);
               use_ff[set_use] <= req_item.bank_mask;
            end else if (req_item.op == OP_POOL_ADD) begin
               pool_ff <= pool_ff | req_item.bank_mask;
            end else if (req_item.op <= OP_RESET_SUBOBJEXT) begin
               pool_ff         <= pool_ff | use_ff[ext_use];
               use_ff[ext_use] <= '0;
            end else if (req_item.op == OP_DISABLE_POOL) begin
               pool_ff <= '0;
            end else begin
               pool_ff <= pool_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff          <= req_item.op;
         mask_ff        <= req_item.bank_mask;
         idx_ff         <= '0;
         bank_ff        <= '0;
         sweep_value_ff <= VAL_POOL;
         ret_ff         <= '0;
         priority if (req_item.op < OP_POOL_ADD) begin
            sweep_mask_ff <= ~req_item.bank_mask & (pool_ff | use_ff[set_use]);
         end else if (req_item.op == OP_POOL_ADD) begin
            sweep_mask_ff <= req_item.bank_mask;
         end else if (req_item.op <= OP_RESET_SUBOBJEXT) begin
            sweep_mask_ff <= use_ff[ext_use];
            ret_ff        <= use_ff[ext_use];
         end else if (req_item.op == OP_DISABLE_POOL) begin
            sweep_mask_ff  <= pool_ff;
            sweep_value_ff <= VAL_DISABLE;
            ret_ff         <= pool_ff;
         end else begin
            sweep_mask_ff <= '0;
         end
      end else begin
         if (idx_inc) idx_ff <= idx_ff + 2'd1;
         if (bank_inc && bank_ff != 4'(NUM_BANKS - 1)) bank_ff <= bank_ff + 4'd1;
      end
      if (emit_tbl) begin
         rsp_ff.write_target  <= entry.target;
         rsp_ff.write_value   <= entry.value;
         rsp_ff.returned_mask <= '0;
         rsp_ff.last          <= 1'b0;
      end else if (emit_bank) begin
         rsp_ff.write_target  <= bank_ff;
         rsp_ff.write_value   <= sweep_value_ff;
         rsp_ff.returned_mask <= '0;
         rsp_ff.last          <= 1'b0;
      end else if (emit_done) begin
         rsp_ff.write_target  <= TGT_DONE;
         rsp_ff.write_value   <= '0;
         rsp_ff.returned_mask <= ret_ff;
         rsp_ff.last          <= 1'b1;
      end
   end

   a_last_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> rsp_ff.write_target == TGT_DONE)
      else $error("last item without done target");

   a_ret_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> rsp_ff.returned_mask == '0)
      else $error("returned mask on a non-done item");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_TABLE && idx_ff == '0 && bank_ff == '0)
      else $error("sequencer did not start on accept");

   a_bank_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWEEP |-> bank_ff <= 4'(NUM_BANKS - 1))
      else $error("bank counter out of range");

   a_done_leaves: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && out_free |=> state_ff == ST_IDLE && rsp_valid_ff && rsp_ff.last)
      else $error("done item not issued");

endmodule

@@ sim/tb_video_bank_assignment.sv @@
module tb_video_bank_assignment;
   import vba_pkg::*;

   localparam logic [3:0] OP_SPARE_LO = 4'd14;
   localparam logic [3:0] OP_SPARE_HI = 4'd15;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   req_type       pending_items[$];
   rsp_type       awaited_writes[$];
   bank_mask_type pool_banks = '0;
   bank_mask_type use_banks [NUM_USES] = '{default: '0};
   int            fail_count  = 0;
   int            cycle_count = 0;
   int            burst_left  = 0;
   int            gap_left    = 0;

   always #4 clock = ~clock;

   video_bank_assignment i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   function automatic req_type make_req(input logic [3:0] op, input bank_mask_type m);
      req_type r;
      r.op        = op;
      r.bank_mask = m;
      return r;
   endfunction

   function automatic void ctl(input logic [3:0] target, input logic [7:0] value);
      rsp_type r;
      r.write_target  = target;
      r.write_value   = value;
      r.returned_mask = '0;
      r.last          = 1'b0;
      awaited_writes.push_back(r);
   endfunction

   function automatic void sweep_banks(input bank_mask_type m, input logic [7:0] value);
      for (int b = 0; b < NUM_BANKS; b++) begin
         if (m[b]) ctl(4'(b), value);
      end
   endfunction

   // per-use control writes, keyed on the whole mask
   function automatic void use_table_writes(input logic [3:0] op, input bank_mask_type m);
      case (op)
         OP_SET_BG: begin
            case (m)
               9'h001: ctl(TGT_BANK_A, 8'h81);
               9'h002: ctl(TGT_BANK_B, 8'h81);
               9'h003: begin
                  ctl(TGT_BANK_B, 8'h89); ctl(TGT_BANK_A, 8'h81);
               end
               9'h004: ctl(TGT_BANK_C, 8'h81);
               9'h005: begin
                  ctl(TGT_BANK_A, 8'h81); ctl(TGT_BANK_C, 8'h89);
               end
               9'h006: begin
                  ctl(TGT_BANK_C, 8'h89); ctl(TGT_BANK_B, 8'h81);
               end
               9'h007: begin
                  ctl(TGT_BANK_C, 8'h91); ctl(TGT_BANK_B, 8'h89); ctl(TGT_BANK_A, 8'h81);
               end
               9'h008: ctl(TGT_BANK_D, 8'h81);
               9'h009: begin
                  ctl(TGT_BANK_A, 8'h81); ctl(TGT_BANK_D, 8'h89);
               end
               9'h00a: begin
                  ctl(TGT_BANK_B, 8'h81); ctl(TGT_BANK_D, 8'h89);
               end
               9'h00b: begin
                  ctl(TGT_BANK_A, 8'h81); ctl(TGT_BANK_B, 8'h89); ctl(TGT_BANK_D, 8'h91);
               end
               9'h00c: begin
                  ctl(TGT_BANK_D, 8'h89); ctl(TGT_BANK_C, 8'h81);
               end
               9'h00d: begin
                  ctl(TGT_BANK_D, 8'h91); ctl(TGT_BANK_A, 8'h81); ctl(TGT_BANK_C, 8'h89);
               end
               9'h00e: begin
                  ctl(TGT_BANK_D, 8'h91); ctl(TGT_BANK_C, 8'h89); ctl(TGT_BANK_B, 8'h81);
               end
               9'h00f: begin
                  ctl(TGT_BANK_D, 8'h99); ctl(TGT_BANK_C, 8'h91);
                  ctl(TGT_BANK_B, 8'h89); ctl(TGT_BANK_A, 8'h81);
               end
               9'h010: ctl(TGT_BANK_E, 8'h81);
               9'h020: ctl(TGT_BANK_F, 8'h81);
               9'h030: begin
                  ctl(TGT_BANK_F, 8'h91); ctl(TGT_BANK_E, 8'h81);
               end
               9'h040: ctl(TGT_BANK_G, 8'h81);
               9'h050: begin
                  ctl(TGT_BANK_G, 8'h91); ctl(TGT_BANK_E, 8'h81);
               end
               9'h060: begin
                  ctl(TGT_BANK_G, 8'h89); ctl(TGT_BANK_F, 8'h81);
               end
               9'h070: begin
                  ctl(TGT_BANK_G, 8'h99); ctl(TGT_BANK_F, 8'h91); ctl(TGT_BANK_E, 8'h81);
               end
               default: ;
            endcase
         end
         OP_SET_OBJ: begin
            case (m)
               9'h001: ctl(TGT_BANK_A, 8'h82);
               9'h002: ctl(TGT_BANK_B, 8'h82);
               9'h003: begin
                  ctl(TGT_BANK_B, 8'h8a); ctl(TGT_BANK_A, 8'h82);
               end
               9'h010: ctl(TGT_BANK_E, 8'h82);
               9'h020: ctl(TGT_BANK_F, 8'h82);
               9'h030: begin
                  ctl(TGT_BANK_F, 8'h92); ctl(TGT_BANK_E, 8'h82);
               end
               9'h040: ctl(TGT_BANK_G, 8'h82);
               9'h050: begin
                  ctl(TGT_BANK_G, 8'h92); ctl(TGT_BANK_E, 8'h82);
               end
               9'h060: begin
                  ctl(TGT_BANK_G, 8'h8a); ctl(TGT_BANK_F, 8'h82);
               end
               9'h070: begin
                  ctl(TGT_BANK_G, 8'h9a); ctl(TGT_BANK_F, 8'h92); ctl(TGT_BANK_E, 8'h82);
               end
               default: ;
            endcase
         end
         OP_SET_BGEXT: begin
            case (m)
               9'h000: ctl(TGT_DISP_BGEXT, 8'h00);
               9'h010: begin
                  ctl(TGT_DISP_BGEXT, 8'h01); ctl(TGT_BANK_E, 8'h84);
               end
               9'h020: begin
                  ctl(TGT_BANK_F, 8'h84); ctl(TGT_DISP_BGEXT, 8'h01);
               end
               9'h040: begin
                  ctl(TGT_DISP_BGEXT, 8'h01); ctl(TGT_BANK_G, 8'h8c);
               end
               9'h060: begin
                  ctl(TGT_BANK_G, 8'h8c); ctl(TGT_BANK_F, 8'h84); ctl(TGT_DISP_BGEXT, 8'h01);
               end
               default: ;
            endcase
         end
         OP_SET_OBJEXT: begin
            case (m)
               9'h000: ctl(TGT_DISP_OBJEXT, 8'h00);
               9'h020: begin
                  ctl(TGT_DISP_OBJEXT, 8'h01); ctl(TGT_BANK_F, 8'h85);
               end
               9'h040: begin
                  ctl(TGT_DISP_OBJEXT, 8'h01); ctl(TGT_BANK_G, 8'h85);
               end
               default: ;
            endcase
         end
         OP_SET_SUBBG: begin
            case (m)
               9'h004: ctl(TGT_BANK_C, 8'h84);
               9'h080: ctl(TGT_BANK_H, 8'h81);
               9'h180: begin
                  ctl(TGT_BANK_I, 8'h81); ctl(TGT_BANK_H, 8'h81);
               end
               default: ;
            endcase
         end
         OP_SET_SUBOBJ: begin
            case (m)
               9'h008: ctl(TGT_BANK_D, 8'h84);
               9'h100: ctl(TGT_BANK_I, 8'h82);
               default: ;
            endcase
         end
         OP_SET_SUBBGEXT: begin
            case (m)
               9'h000: ctl(TGT_DISP_SBGEXT, 8'h00);
               9'h080: begin
                  ctl(TGT_DISP_SBGEXT, 8'h01); ctl(TGT_BANK_H, 8'h82);
               end
               default: ;
            endcase
         end
         OP_SET_SUBOBJEXT: begin
            case (m)
               9'h000: ctl(TGT_DISP_SOBJEXT, 8'h00);
               9'h100: begin
                  ctl(TGT_DISP_SOBJEXT, 8'h01); ctl(TGT_BANK_I, 8'h83);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_writes(input req_type it);
      logic [3:0]    slot;
      logic [3:0]    disp;
      bank_mask_type freed;
      rsp_type       done;
      freed = '0;
      slot  = '0;
      disp  = '0;
      if (it.op <= OP_SET_SUBOBJEXT) begin
         pool_banks = ~it.bank_mask & (pool_banks | use_banks[it.op[2:0]]);
         use_banks[it.op[2:0]] = it.bank_mask;
         use_table_writes(it.op, it.bank_mask);
         sweep_banks(pool_banks, VAL_POOL);
      end else if (it.op == OP_POOL_ADD) begin
         pool_banks = pool_banks | it.bank_mask;
         sweep_banks(it.bank_mask, VAL_POOL);
      end else if (it.op <= OP_RESET_SUBOBJEXT) begin
         case (it.op)
            OP_RESET_BGEXT: begin
               slot = OP_SET_BGEXT; disp = TGT_DISP_BGEXT;
            end
            OP_RESET_OBJEXT: begin
               slot = OP_SET_OBJEXT; disp = TGT_DISP_OBJEXT;
            end
            OP_RESET_SUBBGEXT: begin
               slot = OP_SET_SUBBGEXT; disp = TGT_DISP_SBGEXT;
            end
            default: begin
               slot = OP_SET_SUBOBJEXT; disp = TGT_DISP_SOBJEXT;
            end
         endcase
         ctl(disp, 8'h00);
         freed = use_banks[slot[2:0]];
         use_banks[slot[2:0]] = '0;
         pool_banks = pool_banks | freed;
         sweep_banks(freed, VAL_POOL);
      end else if (it.op == OP_DISABLE_POOL) begin
         freed = pool_banks;
         pool_banks = '0;
         sweep_banks(freed, VAL_DISABLE);
      end
      done.write_target  = TGT_DONE;
      done.write_value   = 8'h00;
      done.returned_mask = freed;
      done.last          = 1'b1;
      awaited_writes.push_back(done);
   endfunction

   // mask drawn from the keys of one use's table
   function automatic bank_mask_type table_mask(input logic [3:0] op);
      int unsigned r;
      r = $urandom;
      case (op)
         OP_SET_BG: begin
            if (r[0]) return bank_mask_type'($urandom_range(15, 1));
            return bank_mask_type'($urandom_range(7, 1) << 4);
         end
         OP_SET_OBJ: begin
            if (r[0]) return bank_mask_type'($urandom_range(3, 1));
            return bank_mask_type'($urandom_range(7, 1) << 4);
         end
         OP_SET_BGEXT: begin
            case (r % 5)
               0: return 9'h000;
               1: return 9'h010;
               2: return 9'h020;
               3: return 9'h040;
               default: return 9'h060;
            endcase
         end
         OP_SET_OBJEXT: begin
            case (r % 3)
               0: return 9'h000;
               1: return 9'h020;
               default: return 9'h040;
            endcase
         end
         OP_SET_SUBBG: begin
            case (r % 3)
               0: return 9'h004;
               1: return 9'h080;
               default: return 9'h180;
            endcase
         end
         OP_SET_SUBOBJ:   return r[0] ? 9'h008 : 9'h100;
         OP_SET_SUBBGEXT: return r[0] ? 9'h000 : 9'h080;
         default:         return r[0] ? 9'h000 : 9'h100;
      endcase
   endfunction

   task automatic report(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("mismatch %s: got 0x%0h, want 0x%0h, cycle %0d", what, got, want,
                  cycle_count);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_writes(req_item);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_item  <= pending_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(4) == 0) ? 40 : $urandom_range(5);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(24, 1);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      int      phase;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_writes.size() == 0) begin
               report("item with nothing awaited", rsp_item, 0);
            end else begin
               want = awaited_writes.pop_front();
               if (rsp_item.write_target !== want.write_target)
                  report("write_target", rsp_item.write_target, want.write_target);
               if (rsp_item.write_value !== want.write_value)
                  report("write_value", rsp_item.write_value, want.write_value);
               if (rsp_item.returned_mask !== want.returned_mask)
                  report("returned_mask", rsp_item.returned_mask, want.returned_mask);
               if (rsp_item.last !== want.last)
                  report("last", rsp_item.last, want.last);
            end
         end
         phase = (cycle_count / 128) % 4;
         case (phase)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3) == 0);
            2: rsp_stall <= ($urandom_range(3) != 0);
            default: rsp_stall <= ((cycle_count % 3) != 0);
         endcase
      end
   end

   initial begin : stimulus
      int            counted;
      int            pick;
      logic [3:0]    op;
      bank_mask_type m;

      pending_items.push_back(make_req(OP_POOL_ADD, 9'h1ff));
      pending_items.push_back(make_req(OP_SET_BG, 9'h00f));
      pending_items.push_back(make_req(OP_SET_OBJ, 9'h070));
      pending_items.push_back(make_req(OP_SET_SUBBG, 9'h180));
      pending_items.push_back(make_req(OP_SET_SUBOBJ, 9'h008));
      pending_items.push_back(make_req(OP_SET_BGEXT, 9'h060));
      pending_items.push_back(make_req(OP_SET_OBJEXT, 9'h040));
      pending_items.push_back(make_req(OP_SET_SUBBGEXT, 9'h080));
      pending_items.push_back(make_req(OP_SET_SUBOBJEXT, 9'h100));
      pending_items.push_back(make_req(OP_RESET_BGEXT, 9'h1ff));
      pending_items.push_back(make_req(OP_RESET_OBJEXT, 9'h000));
      pending_items.push_back(make_req(OP_RESET_SUBBGEXT, 9'h155));
      pending_items.push_back(make_req(OP_RESET_SUBOBJEXT, 9'h000));
      pending_items.push_back(make_req(OP_SET_BGEXT, 9'h000));
      pending_items.push_back(make_req(OP_SET_BG, 9'h1ff));
      pending_items.push_back(make_req(OP_SET_OBJ, 9'h000));
      pending_items.push_back(make_req(OP_DISABLE_POOL, 9'h1ff));
      pending_items.push_back(make_req(OP_DISABLE_POOL, 9'h000));
      pending_items.push_back(make_req(OP_SPARE_LO, 9'h1ff));
      pending_items.push_back(make_req(OP_SPARE_HI, 9'h0aa));
      pending_items.push_back(make_req(OP_POOL_ADD, 9'h000));
      pending_items.push_back(make_req(OP_POOL_ADD, 9'h1ff));
      pending_items.push_back(make_req(OP_SET_SUBOBJEXT, 9'h000));
      pending_items.push_back(make_req(OP_SET_SUBBG, 9'h1ff));
      pending_items.push_back(make_req(OP_DISABLE_POOL, 9'h000));

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         m    = bank_mask_type'($urandom_range(511));
         if (pick < 50) begin
            op = 4'($urandom_range(OP_SET_SUBOBJEXT, OP_SET_BG));
            m  = table_mask(op);
         end else if (pick < 62) begin
            op = 4'($urandom_range(OP_SET_SUBOBJEXT, OP_SET_BG));
         end else if (pick < 74) begin
            op = OP_POOL_ADD;
         end else if (pick < 86) begin
            op = 4'($urandom_range(OP_RESET_SUBOBJEXT, OP_RESET_BGEXT));
         end else if (pick < 94) begin
            op = OP_DISABLE_POOL;
         end else begin
            op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
         end
         if (op < OP_SPARE_LO) counted++;
         pending_items.push_back(make_req(op, m));
      end

      while (pending_items.size() != 0 || req_valid || awaited_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_writes.size() != 0) report("items never seen", awaited_writes.size(), 0);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/vba_pkg.sv
rtl/video_bank_assignment.sv
sim/tb_video_bank_assignment.sv
